/* hw/rtl/mfrc_pkg.sv */
// ----------------------------------------------------------------------------
// mfrc_pkg
// Shared types, codes and constants of the marker framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrc_pkg;

    // default frame capacity in bytes, end marker included
    localparam int MAX_FRAME_DEF = 32;

    // fixed frame layout
    localparam int REPLAY_LIMIT   = 27;
    localparam int FRAME_OVERHEAD = 5;
    localparam int PARAM_OFFSET   = 3;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PCNT_W   = 5;
    localparam int CFG_IDX_W = 8;

    // register reset values
    localparam logic [BYTE_W-1:0] START_RESET = 8'hF1;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'hF0;
    localparam logic [BYTE_W-1:0] CHECK_MASK  = 8'h7F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd3;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   command;
        logic [PCNT_W-1:0]   param_count;
        logic [PCNT_W-1:0]   param_index;
        logic [BYTE_W-1:0]   param_byte;
        logic                last;
    } t_result;

    // request from the capture logic to the replay unit
    typedef struct packed {
        logic    single;   // load res as a lone result
        logic    launch;   // replay res.param_count stored parameters
        t_result res;
    } t_req;

endpackage

`default_nettype wire

/* hw/rtl/mfrc_mem.sv */
// ----------------------------------------------------------------------------
// mfrc_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrc_mem #(
    parameter int DEPTH  = mfrc_pkg::MAX_FRAME_DEF,
    parameter int ADDR_W = $clog2(mfrc_pkg::MAX_FRAME_DEF)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [mfrc_pkg::BYTE_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [mfrc_pkg::BYTE_W-1:0] o_rd_data
);

    logic [mfrc_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [mfrc_pkg::BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/mfrc_replay.sv */
// ----------------------------------------------------------------------------
// mfrc_replay
// Replay sequencer and output register: reads stored parameters back from the
// frame store and hands them out one word per parameter.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrc_replay #(
    parameter int ADDR_W = $clog2(mfrc_pkg::MAX_FRAME_DEF)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mfrc_pkg::t_req                i_req,
    output logic                               o_room,
    output logic                               o_rd_en,
    output logic      [ADDR_W-1:0]             o_rd_addr,
    input  wire logic [mfrc_pkg::BYTE_W-1:0]   i_rd_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output mfrc_pkg::t_result                  o_res
);

    localparam int PW = mfrc_pkg::PCNT_W;

    logic                        r_active;
    logic [PW-1:0]               r_issue;
    logic [PW-1:0]               r_rd_idx;
    logic                        r_rd_pend;
    logic [PW-1:0]               r_len;
    logic [mfrc_pkg::BYTE_W-1:0] r_cmd;
    logic                        r_out_valid;
    mfrc_pkg::t_result           r_out;

    logic    ld;
    logic    issue;
    logic    out_take;
    logic [6:0] addr_sum;

    // handshake on the result side
    assign out_take = r_out_valid && i_ready;

    // memory word arrives, move it into the output register when free
    assign ld = r_rd_pend && (!r_out_valid || i_ready);

    // one outstanding read at a time
    assign issue = r_active && (r_issue < r_len) && (!r_rd_pend || ld);

    assign addr_sum  = {2'b00, r_issue} + 7'(mfrc_pkg::PARAM_OFFSET);
    assign o_rd_en   = issue;
    assign o_rd_addr = addr_sum[ADDR_W-1:0];

    // new input bytes only while idle and the output can take a word
    assign o_room = !r_active && (!r_out_valid || i_ready);

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_issue   <= '0;
        end else begin
            if (i_req.launch) begin
                r_active <= 1'b1;
                r_issue  <= '0;
            end else begin
                if (issue) begin
                    r_issue <= r_issue + PW'(1);
                end
                if (ld && (r_rd_idx + PW'(1) == r_len)) begin
                    r_active <= 1'b0;
                end
            end
            if (issue) begin
                r_rd_pend <= 1'b1;
            end else if (ld) begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    // frame details and pending index
    always_ff @(posedge i_clk) begin
        if (i_req.launch) begin
            r_len <= i_req.res.param_count;
            r_cmd <= i_req.res.command;
        end
        if (issue) begin
            r_rd_idx <= r_issue;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld || i_req.single) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_req.single) begin
            r_out <= i_req.res;
        end else if (ld) begin
            r_out.status      <= mfrc_pkg::ST_GOOD;
            r_out.command     <= r_cmd;
            r_out.param_count <= r_len;
            r_out.param_index <= r_rd_idx;
            r_out.param_byte  <= i_rd_data;
            r_out.last        <= (r_rd_idx + PW'(1) == r_len);
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // a pending read only exists inside a replay
    a_pend_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> r_active)
        else $error("read pending outside replay");

    // a replay never runs over an empty frame
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_len != '0))
        else $error("replay with zero parameters");

    // the pending read stays within the parameter bytes
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_rd_idx < r_len))
        else $error("replay index beyond length");

    // a lone result or a replay launch never arrives while a replay is busy
    a_single_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.single || i_req.launch) |-> (!r_active && !r_rd_pend))
        else $error("request while replay busy");

endmodule

`default_nettype wire

/* hw/rtl/marker_frame_receiver_checker.sv */
// ----------------------------------------------------------------------------
// marker_frame_receiver_checker
// Marker framed serial receiver with 7-bit checksum test and parameter replay.
//
// Usage: bytes enter on the rx channel (i_rx_valid / o_rx_ready, i_rx_byte),
// one word per byte. A start marker opens a frame, the end marker closes it.
// A good frame comes out on the result channel (o_res_valid / i_res_ready)
// as one word per parameter byte with o_last on the final one, or as one word
// when it has no parameters. A bad check, length mismatch or overrun gives a
// single status word with o_last set.
// A status word or an empty good frame appears in the cycle after the closing
// byte is taken. Replay gives one word a cycle while i_res_ready is high,
// bounded by the single read port of the frame store; the rx channel is held
// off during replay. Otherwise a byte is taken every cycle with room for a result.
// Markers are written on the cfg channel (index 0 start, 1 end; other indexes
// are ignored), always ready. Reset sets the markers to 0xF1 / 0xF0 and drops
// any partial frame; the frame store needs no clearing. When the receiver
// stalls, the result word holds and rx bytes wait.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_frame_receiver_checker #(
    parameter int MAX_FRAME = mfrc_pkg::MAX_FRAME_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // byte input
    input  wire logic                             i_rx_valid,
    output logic                                  o_rx_ready,
    input  wire logic [mfrc_pkg::BYTE_W-1:0]      i_rx_byte,
    // results
    output logic                                  o_res_valid,
    input  wire logic                             i_res_ready,
    output logic      [mfrc_pkg::STATUS_W-1:0]    o_status,
    output logic      [mfrc_pkg::BYTE_W-1:0]      o_command,
    output logic      [mfrc_pkg::PCNT_W-1:0]      o_param_count,
    output logic      [mfrc_pkg::PCNT_W-1:0]      o_param_index,
    output logic      [mfrc_pkg::BYTE_W-1:0]      o_param_byte,
    output logic                                  o_last,
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mfrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mfrc_pkg::BYTE_W-1:0]      i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int BW     = mfrc_pkg::BYTE_W;

    logic [BW-1:0]    r_start_mk;
    logic [BW-1:0]    r_end_mk;
    logic             r_capturing;
    logic [CNT_W-1:0] r_count;
    logic [BW-1:0]    r_cmd;
    logic [BW-1:0]    r_len;
    logic [BW-1:0]    r_chk;
    logic [BW-1:0]    r_sum;

    logic             rx_acc;
    logic             is_start;
    logic             overrun;
    logic             store;
    logic             closing;
    logic             room;
    logic [BW-1:0]    cmd_now;
    logic [8:0]       n_total;
    logic [8:0]       len_total;
    logic [BW-1:0]    sum_body;
    logic [BW-1:0]    chk_calc;
    mfrc_pkg::t_req   req;
    mfrc_pkg::t_result res;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BW-1:0]    rd_data;

    // handshakes
    assign o_rx_ready  = room;
    assign o_cfg_ready = 1'b1;
    assign rx_acc      = i_rx_valid && room;

    // byte classification
    assign is_start = (i_rx_byte == r_start_mk);
    assign overrun  = r_capturing && !is_start && (r_count == CNT_W'(MAX_FRAME));
    assign store    = r_capturing && !is_start && !overrun;
    assign closing  = store && (i_rx_byte == r_end_mk);

    // frame check terms at the closing byte
    assign cmd_now   = (r_count == CNT_W'(1)) ? i_rx_byte : r_cmd;
    assign n_total   = 9'(r_count) + 9'd1;
    assign len_total = {1'b0, r_len} + 9'(mfrc_pkg::FRAME_OVERHEAD);
    assign sum_body  = r_sum - r_chk;
    assign chk_calc  = (~sum_body + 8'd1) & mfrc_pkg::CHECK_MASK;

    // build the request to the replay unit
    always_comb begin
        req = '0;
        req.res.command = cmd_now;
        req.res.last    = 1'b1;
        if (rx_acc && overrun) begin
            req.single      = 1'b1;
            req.res.command = r_cmd;
            req.res.status  = mfrc_pkg::ST_OVERRUN;
        end else if (rx_acc && closing) begin
            priority if (n_total < 9'(mfrc_pkg::FRAME_OVERHEAD)) begin
                req.single     = 1'b1;
                req.res.status = mfrc_pkg::ST_LEN_ERR;
            end else if ((n_total != len_total)
                         || (r_len > BW'(mfrc_pkg::REPLAY_LIMIT))) begin
                req.single     = 1'b1;
                req.res.status = mfrc_pkg::ST_LEN_ERR;
            end else if (chk_calc != r_chk) begin
                req.single     = 1'b1;
                req.res.status = mfrc_pkg::ST_BAD_CHK;
            end else if (r_len == '0) begin
                req.single     = 1'b1;
                req.res.status = mfrc_pkg::ST_GOOD;
            end else begin
                req.launch          = 1'b1;
                req.res.status      = mfrc_pkg::ST_GOOD;
                req.res.param_count = r_len[mfrc_pkg::PCNT_W-1:0];
            end
        end
    end

    // marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mk <= mfrc_pkg::START_RESET;
            r_end_mk   <= mfrc_pkg::END_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mfrc_pkg::CFG_START_MARKER) begin
                r_start_mk <= i_cfg_data;
            end else if (i_cfg_index == mfrc_pkg::CFG_END_MARKER) begin
                r_end_mk <= i_cfg_data;
            end
        end
    end

    // capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_count     <= '0;
        end else if (rx_acc) begin
            if (is_start) begin
                r_capturing <= 1'b1;
                r_count     <= CNT_W'(1);
            end else if (overrun || closing) begin
                r_capturing <= 1'b0;
                r_count     <= '0;
            end else if (store) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // running header, check byte and sum tracking
    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            if (is_start) begin
                r_sum <= '0;
            end else if (store) begin
                r_sum <= r_sum + i_rx_byte;
                r_chk <= i_rx_byte;
                if (r_count == CNT_W'(1)) begin
                    r_cmd <= i_rx_byte;
                end
                if (r_count == CNT_W'(2)) begin
                    r_len <= i_rx_byte;
                end
            end
        end
    end

    mfrc_mem #(
        .DEPTH  (MAX_FRAME),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (rx_acc && (is_start || store)),
        .i_wr_addr (is_start ? '0 : r_count[ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mfrc_replay #(
        .ADDR_W (ADDR_W)
    ) u_replay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_room    (room),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_res_valid),
        .i_ready   (i_res_ready),
        .o_res     (res)
    );

    assign o_status      = res.status;
    assign o_command     = res.command;
    assign o_param_count = res.param_count;
    assign o_param_index = res.param_index;
    assign o_param_byte  = res.param_byte;
    assign o_last        = res.last;

    // byte count never exceeds the frame capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAME))
        else $error("byte count beyond frame capacity");

    // count is zero whenever no frame is open
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_capturing |-> (r_count == '0))
        else $error("stale byte count while idle");

endmodule

`default_nettype wire
